@@ hw/rtl/rectified_moving_average_8ch_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the rectified moving average block
// Clocked implication checks with a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef RECTIFIED_MOVING_AVERAGE_8CH_ASSERT_SVH
`define RECTIFIED_MOVING_AVERAGE_8CH_ASSERT_SVH

// Same-cycle implication.
`define RMA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rma_pkg.sv @@
// ----------------------------------------------------------------------------
// rma_pkg
// Types, constants and helpers shared by the rectified moving average block.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int CHANNELS       = 8;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int SAMPLE_W       = 8;
    localparam int LEN_W          = 5;
    localparam int CH_W           = $clog2(CHANNELS);
    localparam logic [LEN_W-1:0] WINDOW_RESET = 5'd10;

    // Running sum width for a given ring depth (worst case depth * 128).
    function automatic int sum_width(input int max_window);
        return $clog2(max_window * 128 + 1);
    endfunction

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
        logic signed [SAMPLE_W-1:0] sample_ch4;
        logic signed [SAMPLE_W-1:0] sample_ch5;
        logic signed [SAMPLE_W-1:0] sample_ch6;
        logic signed [SAMPLE_W-1:0] sample_ch7;
    } in_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean_ch0;
        logic [SAMPLE_W-1:0] mean_ch1;
        logic [SAMPLE_W-1:0] mean_ch2;
        logic [SAMPLE_W-1:0] mean_ch3;
        logic [SAMPLE_W-1:0] mean_ch4;
        logic [SAMPLE_W-1:0] mean_ch5;
        logic [SAMPLE_W-1:0] mean_ch6;
        logic [SAMPLE_W-1:0] mean_ch7;
        logic                window_full;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_STORE,
        ST_DONE
    } rma_state_t;

    typedef struct packed {
        logic            accept;
        logic            rd_issue;
        logic            update;
        logic            div_step;
        logic            store;
        logic            load_out;
        logic [CH_W-1:0] ch;
    } rma_cmd_t;

    typedef struct packed {
        logic out_busy;
    } rma_status_t;

endpackage

@@ hw/rtl/rma_ctrl.sv @@
// ----------------------------------------------------------------------------
// rma_ctrl
// Sequencer: walks the channels through read, update, divide and store steps.
// ----------------------------------------------------------------------------
module rma_ctrl #(
    parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output rma_pkg::rma_cmd_t    cmd,
    input  rma_pkg::rma_status_t status
);

    localparam int SUM_W  = rma_pkg::sum_width(MAX_WINDOW);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
    localparam logic [rma_pkg::CH_W-1:0] LAST_CH = rma_pkg::CH_W'(rma_pkg::CHANNELS - 1);

    rma_pkg::rma_state_t state_reg, state_next;
    logic [rma_pkg::CH_W-1:0] ch_reg, ch_next;
    logic [STEP_W-1:0]        step_reg, step_next;

    logic last_step;
    logic last_ch;

    assign last_step = (step_reg == LAST_STEP);
    assign last_ch   = (ch_reg == LAST_CH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rma_pkg::ST_IDLE;
            ch_reg    <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    // next state and counters
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        unique case (state_reg)
            rma_pkg::ST_IDLE: begin
                ch_next = '0;
                if (s_valid) begin
                    state_next = rma_pkg::ST_READ;
                end
            end
            rma_pkg::ST_READ: begin
                state_next = rma_pkg::ST_UPDATE;
            end
            rma_pkg::ST_UPDATE: begin
                step_next  = '0;
                state_next = rma_pkg::ST_DIVIDE;
            end
            rma_pkg::ST_DIVIDE: begin
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    state_next = rma_pkg::ST_STORE;
                end
            end
            rma_pkg::ST_STORE: begin
                if (last_ch) begin
                    state_next = rma_pkg::ST_DONE;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = rma_pkg::ST_READ;
                end
            end
            rma_pkg::ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = rma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rma_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        cmd.ch  = ch_reg;
        s_ready = 1'b0;
        unique case (state_reg)
            rma_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            rma_pkg::ST_READ:   cmd.rd_issue = 1'b1;
            rma_pkg::ST_UPDATE: cmd.update   = 1'b1;
            rma_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
            rma_pkg::ST_STORE:  cmd.store    = 1'b1;
            rma_pkg::ST_DONE:   cmd.load_out = !status.out_busy;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/rma_dp.sv @@
// ----------------------------------------------------------------------------
// rma_dp
// Datapath: sample ring memory, running sums, shared divider, result register.
// ----------------------------------------------------------------------------
module rma_dp #(
    parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rma_pkg::in_beat_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rma_pkg::out_beat_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [rma_pkg::LEN_W-1:0]     cfg_wr_data,
    input  rma_pkg::rma_cmd_t             cmd,
    output rma_pkg::rma_status_t          status
);

    localparam int SUM_W  = rma_pkg::sum_width(MAX_WINDOW);
    localparam int NW     = ($clog2(MAX_WINDOW + 1) > rma_pkg::LEN_W) ?
                            $clog2(MAX_WINDOW + 1) : rma_pkg::LEN_W;
    localparam int IW     = NW + 1;
    localparam int SW     = $clog2(MAX_WINDOW);
    localparam int DEPTH  = rma_pkg::CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SMP_W  = rma_pkg::SAMPLE_W;

    // configuration and window bookkeeping
    logic [rma_pkg::LEN_W-1:0] wlen_reg;
    logic [NW-1:0]             fill_reg;
    logic [SW-1:0]             wslot_reg;
    logic [SW-1:0]             item_slot_reg;
    logic [SW-1:0]             old_slot_reg;
    logic                      was_full_reg;
    logic                      full_reg;

    logic [NW-1:0] wlen_ext;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] fill_next;
    logic [IW-1:0] old_tmp;
    logic [SW-1:0] old_slot_next;
    logic [SW-1:0] wslot_next;

    // per-item data
    logic [SMP_W-1:0] smp     [rma_pkg::CHANNELS];
    logic [SMP_W-1:0] rect_reg[rma_pkg::CHANNELS];
    logic [SUM_W-1:0] sum_reg [rma_pkg::CHANNELS];
    logic [SMP_W-1:0] mean_reg[rma_pkg::CHANNELS];

    // ring memory
    logic [SMP_W-1:0]  hist_mem [DEPTH];
    logic [SMP_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] ch_base;

    // divider
    logic [IW-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [IW-1:0]    rem_sh;
    logic [SUM_W-1:0] sum_new;

    // result register
    logic               m_valid_reg;
    rma_pkg::out_beat_t m_data_reg;

    assign smp[0] = s_data.sample_ch0;
    assign smp[1] = s_data.sample_ch1;
    assign smp[2] = s_data.sample_ch2;
    assign smp[3] = s_data.sample_ch3;
    assign smp[4] = s_data.sample_ch4;
    assign smp[5] = s_data.sample_ch5;
    assign smp[6] = s_data.sample_ch6;
    assign smp[7] = s_data.sample_ch7;

    // effective window: zero reads as one, clamp to ring depth
    always_comb begin
        wlen_ext = NW'(wlen_reg);
        if (wlen_reg == '0) begin
            n_eff = NW'(1);
        end else if (wlen_ext > NW'(MAX_WINDOW)) begin
            n_eff = NW'(MAX_WINDOW);
        end else begin
            n_eff = wlen_ext;
        end
    end

    always_comb begin
        fill_next = (fill_reg < n_eff) ? fill_reg + 1'b1 : fill_reg;
        old_tmp   = IW'(wslot_reg) + IW'(MAX_WINDOW) - IW'(n_eff);
        if (old_tmp >= IW'(MAX_WINDOW)) begin
            old_slot_next = SW'(old_tmp - IW'(MAX_WINDOW));
        end else begin
            old_slot_next = SW'(old_tmp);
        end
        if (wslot_reg == SW'(MAX_WINDOW - 1)) begin
            wslot_next = '0;
        end else begin
            wslot_next = wslot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg  <= rma_pkg::WINDOW_RESET;
            fill_reg  <= '0;
            wslot_reg <= '0;
        end else if (cfg_wr_en) begin
            wlen_reg  <= cfg_wr_data;
            fill_reg  <= '0;
            wslot_reg <= '0;
        end else if (cmd.accept) begin
            fill_reg  <= fill_next;
            wslot_reg <= wslot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_slot_reg <= wslot_reg;
            old_slot_reg  <= old_slot_next;
            was_full_reg  <= (fill_reg >= n_eff);
            full_reg      <= (fill_next >= n_eff);
            for (int c = 0; c < rma_pkg::CHANNELS; c++) begin
                rect_reg[c] <= smp[c][SMP_W-1] ? SMP_W'(~smp[c] + 1'b1) : smp[c];
            end
        end
    end

    // ring memory, one row of MAX_WINDOW entries per channel
    assign ch_base = ADDR_W'(cmd.ch) * ADDR_W'(MAX_WINDOW);
    assign rd_addr = ch_base + ADDR_W'(old_slot_reg);
    assign wr_addr = ch_base + ADDR_W'(item_slot_reg);

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
        if (cmd.update) begin
            hist_mem[wr_addr] <= rect_reg[cmd.ch];
        end
    end

    // running sums
    assign sum_new = sum_reg[cmd.ch] + SUM_W'(rect_reg[cmd.ch])
                   - (was_full_reg ? SUM_W'(rd_data_reg) : SUM_W'(0));

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            for (int c = 0; c < rma_pkg::CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (cmd.update) begin
            sum_reg[cmd.ch] <= sum_new;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg[NW-1:0], dq_reg[SUM_W-1]};

    always_comb begin
        rem_next = rem_reg;
        dq_next  = dq_reg;
        if (cmd.update) begin
            rem_next = '0;
            dq_next  = sum_new;
        end else if (cmd.div_step) begin
            if (rem_sh >= IW'(n_eff)) begin
                rem_next = rem_sh - IW'(n_eff);
                dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (cmd.store) begin
            mean_reg[cmd.ch] <= full_reg ? dq_reg[SMP_W-1:0] : '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.mean_ch0    <= mean_reg[0];
            m_data_reg.mean_ch1    <= mean_reg[1];
            m_data_reg.mean_ch2    <= mean_reg[2];
            m_data_reg.mean_ch3    <= mean_reg[3];
            m_data_reg.mean_ch4    <= mean_reg[4];
            m_data_reg.mean_ch5    <= mean_reg[5];
            m_data_reg.mean_ch6    <= mean_reg[6];
            m_data_reg.mean_ch7    <= mean_reg[7];
            m_data_reg.window_full <= full_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

endmodule

@@ hw/rtl/rectified_moving_average_8ch.sv @@
// ----------------------------------------------------------------------------
// rectified_moving_average_8ch
// A new input beat is taken only after the previous result has been loaded into the result
// register, which waits while m_ready still holds the older result; the shared restoring
// divider, walked channel by channel, sets the pace.
// Reset (sync, active low): sums, fill count, ring slot cleared, window length 10;
// ring history is not cleared, a read entry only enters the sum after it was written.
// ----------------------------------------------------------------------------
module rectified_moving_average_8ch #(
    parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // sample beats in
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rma_pkg::in_beat_t          s_data,
    // mean beats out
    output logic                       m_valid,
    input  logic                       m_ready,
    output rma_pkg::out_beat_t         m_data,
    // window length register
    input  logic                       cfg_wr_en,
    input  logic [rma_pkg::LEN_W-1:0]  cfg_wr_data
);

    // Per beat the sequencer walks channel 0..7:
    //   READ   - fetch the sample leaving the window from the ring
    //   UPDATE - running sum += new - old (old once full), new sample written into the ring
    //   DIVIDE - SUM_W restoring steps, sum / effective window
    //   STORE  - latch the mean (zero until the window has filled)
    // DONE waits for the result register to free up, then loads it.
    // The input side reopens as soon as the result is loaded, so the next
    // beat is taken while the last result still waits downstream.

    rma_pkg::rma_cmd_t    cmd;
    rma_pkg::rma_status_t status;

    rma_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // A window length write also restarts the averaging (sums, fill, slot).
    rma_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

@@ hw/rtl/rma_checker.sv @@
// ----------------------------------------------------------------------------
// rma_checker
// Port-level checks for the rectified moving average block.
// ----------------------------------------------------------------------------
`include "rectified_moving_average_8ch_assert.svh"

module rma_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input rma_pkg::in_beat_t         s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input rma_pkg::out_beat_t        m_data
);

    logic means_zero;

    assign means_zero = (m_data.mean_ch0 == '0) && (m_data.mean_ch1 == '0)
                     && (m_data.mean_ch2 == '0) && (m_data.mean_ch3 == '0)
                     && (m_data.mean_ch4 == '0) && (m_data.mean_ch5 == '0)
                     && (m_data.mean_ch6 == '0) && (m_data.mean_ch7 == '0);

    `RMA_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data), "sample beat changed while waiting")
    `RMA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")
    `RMA_ASSERT_SAME(a_zero_unfilled, aclk, aresetn, m_valid && !m_data.window_full, means_zero, "nonzero mean before window filled")
    `RMA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready right after a beat was taken")
    `RMA_ASSERT_SAME(a_ready_on_result, aclk, aresetn, $rose(m_valid), s_ready, "input side not reopened with new result")

endmodule

bind rectified_moving_average_8ch rma_checker u_rma_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

@@ sim/rectified_moving_average_8ch_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rectified_moving_average_8ch_test
// Self-checking bench for the eight-channel rectified moving average. A local
// model tracks the ring, the running sums and the fill count. It predicts one
// mean beat per sample beat and checks every output beat against the oldest
// prediction. Both handshakes stall at random. The window length is
// rewritten between drained phases.
// ----------------------------------------------------------------------------
module rectified_moving_average_8ch_test;

    localparam int  CHANNELS       = rma_pkg::CHANNELS;
    localparam int  MAX_WINDOW_DEF = rma_pkg::MAX_WINDOW_DEF;
    localparam int  CLK_HALF     = 6;
    localparam int  TOTAL_ITEMS  = 1500;
    localparam int  DRAIN_CYCLES = 150;
    localparam int  OUT_W        = CHANNELS * rma_pkg::SAMPLE_W + 1;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    rma_pkg::in_beat_t          s_data  = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    rma_pkg::out_beat_t         m_data;
    logic                       cfg_wr_en   = 1'b0;
    logic [rma_pkg::LEN_W-1:0]  cfg_wr_data = '0;

    rectified_moving_average_8ch u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Local model state: window register, ring of rectified samples,
    // per-channel running sums, fill count and ring write position.
    // ------------------------------------------------------------------
    logic [rma_pkg::LEN_W-1:0] win_len = rma_pkg::WINDOW_RESET;
    logic [7:0]       ring_mag [CHANNELS][MAX_WINDOW_DEF];
    logic [11:0]      run_sum  [CHANNELS];
    int               fill_cnt = 0;
    int               wr_slot  = 0;

    rma_pkg::in_beat_t  sample_queue [$];     // beats waiting for the driver
    rma_pkg::out_beat_t mean_q       [$];     // predicted mean beats, oldest first

    int  error_count  = 0;
    int  items_queued = 0;
    int  items_taken  = 0;
    int  beats_checked = 0;
    int  cfg_writes   = 0;
    bit  in_taken     = 1'b0;        // sample beat accepted at the last rising edge
    bit  quiet_mode   = 1'b0;        // phase without any idling on either side

    // Restart of the averaging, as done by reset and by every register write.
    function automatic void clear_window();
        for (int c = 0; c < CHANNELS; c++) begin
            run_sum[c] = '0;
        end
        fill_cnt = 0;
        wr_slot  = 0;
    endfunction

    // Model one sample beat, return the mean beat it produces.
    function automatic rma_pkg::out_beat_t average_step(input rma_pkg::in_beat_t beat);
        logic [OUT_W-1:0] res;
        int               n;
        int               slot;
        int               old_slot;
        int               raw;
        int               mag;
        int               acc;
        bit               was_full;
        bit               full;
        // zero acts as one, anything past the ring depth saturates
        n = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len);
        slot     = wr_slot % MAX_WINDOW_DEF;
        old_slot = (slot + MAX_WINDOW_DEF - n) % MAX_WINDOW_DEF;
        was_full = (fill_cnt >= n);
        for (int c = 0; c < CHANNELS; c++) begin
            raw = $signed(beat[63-8*c -: 8]);
            mag = (raw < 0) ? -raw : raw;
            acc = run_sum[c] + mag;
            // the leaving sample is read before its slot is overwritten
            if (was_full) begin
                acc = acc - ring_mag[c][old_slot];
            end
            ring_mag[c][slot] = mag[7:0];
            run_sum[c] = acc[11:0];
        end
        wr_slot = (slot + 1) % MAX_WINDOW_DEF;
        if (fill_cnt < n) begin
            fill_cnt++;
        end
        full = (fill_cnt >= n);
        res = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            res[OUT_W-1-8*c -: 8] = full ? 8'(run_sum[c] / n) : 8'd0;
        end
        res[0] = full;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(20, 200);
    endfunction

    function automatic rma_pkg::in_beat_t make_beat(input int v0, v1, v2, v3, v4, v5, v6, v7);
        rma_pkg::in_beat_t b;
        b.sample_ch0 = v0[7:0];
        b.sample_ch1 = v1[7:0];
        b.sample_ch2 = v2[7:0];
        b.sample_ch3 = v3[7:0];
        b.sample_ch4 = v4[7:0];
        b.sample_ch5 = v5[7:0];
        b.sample_ch6 = v6[7:0];
        b.sample_ch7 = v7[7:0];
        return b;
    endfunction

    // Random sample: mostly uniform, with extremes mixed in.
    function automatic logic [7:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h80;    // -128, rectifies to 128
            1:       return 8'h7f;
            2:       return 8'h00;
            3:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_beat(input rma_pkg::in_beat_t b);
        sample_queue = {sample_queue, b};
        items_queued++;
    endtask

    task automatic queue_random(input int count);
        rma_pkg::in_beat_t b;
        for (int i = 0; i < count; i++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                b[63-8*c -: 8] = draw_sample();
            end
            queue_beat(b);
        end
    endtask

    // Wait until every queued beat went in and every predicted beat came out.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_valid || mean_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Register write on a drained block; the model restarts at the same edge.
    task automatic load_window_length(input logic [rma_pkg::LEN_W-1:0] len);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        win_len = len;
        clear_window();
        cfg_writes++;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 5'($urandom_range(0, 31));
    endtask

    // ------------------------------------------------------------------
    // Sample driver: changes at the falling edge, holds a beat until taken.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // beat still offered, keep it steady
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            s_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
            s_data  <= sample_queue[0];
            sample_queue.delete(0);
            s_valid <= 1'b1;
            gap_left = draw_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure on m_ready.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                stall_left = draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sampled at the rising edge. Output beats are checked
    // against the oldest prediction, accepted input beats feed the model.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_beats
        rma_pkg::out_beat_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (mean_q.size() == 0) begin
                    $display("%0t: unexpected mean beat %h", $time, m_data);
                    error_count++;
                end else begin
                    want = mean_q[0];
                    mean_q.delete(0);
                    beats_checked++;
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (m_data[OUT_W-1-8*c -: 8] !== want[OUT_W-1-8*c -: 8]) begin
                            $display("%0t: mean_ch%0d expected %0d actual %0d", $time, c,
                                     want[OUT_W-1-8*c -: 8], m_data[OUT_W-1-8*c -: 8]);
                            error_count++;
                        end
                    end
                    if (m_data.window_full !== want.window_full) begin
                        $display("%0t: window_full expected %0b actual %0b", $time,
                                 want.window_full, m_data.window_full);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                mean_q = {mean_q, average_step(s_data)};
                items_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    localparam int FIXED_PHASES = 12;
    int phase_len [FIXED_PHASES] = '{31, 16, 16, 1, 2, 10, 10, 17, 0, 3, 16, 24};
    int phase_cnt [FIXED_PHASES] = '{40, 7, 60, 30, 40, 25, 120, 100, 50, 100, 130, 90};

    initial begin
        int p;
        int len;
        int cnt;
        clear_window();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset window of 10, extremes, fill then slide.
        queue_beat(make_beat(-128, -128, -128, -128, -128, -128, -128, -128));
        queue_beat(make_beat(127, 127, 127, 127, 127, 127, 127, 127));
        queue_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0));
        queue_beat(make_beat(-1, -1, -1, -1, -1, -1, -1, -1));
        queue_beat(make_beat(1, 1, 1, 1, 1, 1, 1, 1));
        queue_beat(make_beat(-128, 127, -128, 127, -128, 127, -128, 127));
        queue_beat(make_beat(127, -128, 127, -128, 127, -128, 127, -128));
        queue_beat(make_beat(-64, -48, -32, -16, 0, 16, 32, 48));
        queue_beat(make_beat(-127, 126, -2, 2, -85, 85, -100, 99));
        queue_beat(make_beat(-128, -128, -128, -128, -128, -128, -128, -128));
        queue_beat(make_beat(-128, -128, -128, -128, -128, -128, -128, -128));
        queue_beat(make_beat(5, -7, 9, -11, 13, -15, 17, -19));

        // Zero length acts as a window of one.
        load_window_length(5'd0);
        queue_beat(make_beat(-128, 127, 0, -1, 1, -2, 64, -64));
        queue_beat(make_beat(127, -128, -1, 0, -2, 1, -64, 64));
        queue_beat(make_beat(0, 0, -128, 127, 0, 0, 127, -128));

        // Random phases; each begins with a rewrite on a drained block,
        // so the sender also pauses until every result is back.
        p = 0;
        while (items_queued < TOTAL_ITEMS) begin
            if (p < FIXED_PHASES) begin
                len = phase_len[p];
                cnt = phase_cnt[p];
            end else begin
                len = $urandom_range(0, 31);
                cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 14)
                                                  : $urandom_range(80, 160);
            end
            load_window_length(5'(len));
            quiet_mode = ($urandom_range(0, 3) == 0);
            queue_random(cnt);
            p++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mean_q.size() != 0) begin
            $display("%0t: %0d predicted mean beats never arrived", $time, mean_q.size());
            error_count++;
        end
        $display("Covered %0d sample beats, %0d mean beats checked, %0d window writes",
                 items_taken, beats_checked, cfg_writes);
        $display("(lengths 0 to 31, restarts before and after a full window, random stalls)");
        if (error_count == 0) begin
            $display("rectified_moving_average_8ch verification clean");
        end else begin
            $display("rectified_moving_average_8ch verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #40_000_000;
        $display("rectified_moving_average_8ch verification failed");
        $finish;
    end

endmodule
